@@ hw/rtl/display_init_command_list_player_top_defines.svh @@
// Assertion macros for the display init command list player.
// Included by the RTL file that carries concurrent checks (dicl_list_fsm); no dependencies.
`ifndef DISPLAY_INIT_COMMAND_LIST_PLAYER_TOP_DEFINES_SVH
`define DISPLAY_INIT_COMMAND_LIST_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DICL_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dicl check failed");

// Next-cycle implication, disabled while reset is high.
`define DICL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dicl check failed");

`endif

@@ hw/rtl/dicl_pkg.sv @@
// Shared types and constants for the display init command list player.
// No dependencies.
package dicl_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned ARGS_W  = 7;

   localparam logic [BYTE_W-1:0]  LONG_MARKER = 8'd255;
   localparam logic [VALUE_W-1:0] LONG_RESET  = 16'd500;

   typedef enum logic [1:0] {
      KIND_CMD   = 2'd0,
      KIND_ARG   = 2'd1,
      KIND_DELAY = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_COUNT = 5'b00001,
      PH_CMD   = 5'b00010,
      PH_NARGS = 5'b00100,
      PH_ARG   = 5'b01000,
      PH_DELAY = 5'b10000
   } phase_type;

   typedef struct packed {
      kind_type            kind;
      logic [VALUE_W-1:0]  value;
      logic                data_not_command;
      logic                frame_end;
      logic                list_done;
   } result_type;

endpackage

@@ hw/rtl/dicl_req_if.sv @@
// List byte input channel: valid/ready plus one list byte per word.
// Depends on dicl_pkg.
interface dicl_req_if;
   logic                         valid;
   logic                         ready;
   logic [dicl_pkg::BYTE_W-1:0]  list_byte;

   modport source (output valid, output list_byte, input ready);
   modport sink (input valid, input list_byte, output ready);
endinterface

@@ hw/rtl/dicl_rsp_if.sv @@
// Link event output channel: valid/ready plus one result per word.
// Depends on dicl_pkg.
interface dicl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    out_kind;
   logic [dicl_pkg::VALUE_W-1:0]  out_value;
   logic                          data_not_command;
   logic                          frame_end;
   logic                          list_done;

   modport source (output valid, output out_kind, output out_value,
                   output data_not_command, output frame_end, output list_done,
                   input ready);
   modport sink (input valid, input out_kind, input out_value,
                 input data_not_command, input frame_end, input list_done,
                 output ready);
endinterface

@@ hw/rtl/dicl_csr_if.sv @@
// Register write channel: valid/ready plus the long delay value.
// Depends on dicl_pkg.
interface dicl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dicl_pkg::VALUE_W-1:0]  long_delay_ms;

   modport source (output valid, output long_delay_ms, input ready);
   modport sink (input valid, input long_delay_ms, output ready);
endinterface

@@ hw/rtl/display_init_command_list_player_top.sv @@
// Top level of the display init command list player: input register,
// long delay register, phase machine and result register.
// Depends on dicl_pkg, the channel interfaces, dicl_list_fsm, dicl_out_reg.
//
//   channel   dir  word
//   req_port  in   list_byte (8 bit)
//   rsp_port  out  out_kind, out_value, data_not_command, frame_end, list_done
//   csr_port  in   long_delay_ms (16 bit), always ready
//
// One list byte per cycle while the result channel is not stalled; a result
// word passes through the input register, then the result register, before
// it is offered.
// Reset is synchronous: phase machine expects a list count, long delay is 500.
// A stalled result holds the result register; the input register still
// drains quiet bytes only when the result register can load.
module display_init_command_list_player_top (
   input  logic        clock,
   input  logic        reset,
   dicl_req_if.sink    req_port,
   dicl_rsp_if.source  rsp_port,
   dicl_csr_if.sink    csr_port
);

   logic                          in_valid_ff, in_valid_in;
   logic [dicl_pkg::BYTE_W-1:0]   in_byte_ff;
   logic [dicl_pkg::VALUE_W-1:0]  long_delay_ff;
   logic                          can_load;
   logic                          step;
   logic                          res_valid;
   dicl_pkg::result_type          res;
   logic                          req_take;

   assign step          = in_valid_ff && can_load;
   assign req_port.ready = !in_valid_ff || can_load;
   assign req_take      = req_port.valid && req_port.ready;
   assign in_valid_in   = req_take || (in_valid_ff && !can_load);
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         long_delay_ff <= dicl_pkg::LONG_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_port.valid) begin
            long_delay_ff <= csr_port.long_delay_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_port.list_byte;
      end
   end

   dicl_list_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .in_byte    (in_byte_ff),
      .long_delay (long_delay_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   dicl_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (step && res_valid),
      .res      (res),
      .can_load (can_load),
      .rsp_port (rsp_port)
   );

endmodule

@@ hw/rtl/dicl_list_fsm.sv @@
// Command list phase machine: holds list state, decodes one byte per step.
// Depends on dicl_pkg and the defines header.
`include "display_init_command_list_player_top_defines.svh"

module dicl_list_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [dicl_pkg::BYTE_W-1:0]   in_byte,
   input  logic [dicl_pkg::VALUE_W-1:0]  long_delay,
   output logic                          res_valid,
   output dicl_pkg::result_type          res
);

   dicl_pkg::phase_type           phase_ff, phase_in;
   logic [dicl_pkg::BYTE_W-1:0]   cmds_left_ff, cmds_left_in;
   logic [dicl_pkg::ARGS_W-1:0]   args_left_ff, args_left_in;
   logic                          delay_pend_ff, delay_pend_in;
   logic [dicl_pkg::BYTE_W-1:0]   held_cmd_ff, held_cmd_in;

   logic [dicl_pkg::BYTE_W-1:0]   cmds_dec;
   logic [dicl_pkg::ARGS_W-1:0]   args_dec;
   dicl_pkg::phase_type           finish_phase;
   logic                          last_cmd;

   assign cmds_dec     = cmds_left_ff - 8'd1;
   assign args_dec     = args_left_ff - 7'd1;
   assign finish_phase = (cmds_dec == '0) ? dicl_pkg::PH_COUNT : dicl_pkg::PH_CMD;
   assign last_cmd     = (cmds_left_ff == 8'd1);

   always_comb begin
      phase_in      = phase_ff;
      cmds_left_in  = cmds_left_ff;
      args_left_in  = args_left_ff;
      delay_pend_in = delay_pend_ff;
      held_cmd_in   = held_cmd_ff;
      res_valid     = 1'b0;
      res.kind             = dicl_pkg::KIND_EMPTY;
      res.value            = '0;
      res.data_not_command = 1'b1;
      res.frame_end        = 1'b0;
      res.list_done        = 1'b0;
      case (phase_ff)
         dicl_pkg::PH_CMD: begin
            held_cmd_in = in_byte;
            phase_in    = dicl_pkg::PH_NARGS;
         end
         dicl_pkg::PH_NARGS: begin
            res_valid            = 1'b1;
            args_left_in         = in_byte[dicl_pkg::ARGS_W-1:0];
            delay_pend_in        = in_byte[dicl_pkg::BYTE_W-1];
            res.kind             = dicl_pkg::KIND_CMD;
            res.value            = {8'd0, held_cmd_ff};
            res.data_not_command = 1'b0;
            res.frame_end        = (args_left_in == '0);
            res.list_done        = res.frame_end && !delay_pend_in && last_cmd;
            if (args_left_in != '0) begin
               phase_in = dicl_pkg::PH_ARG;
            end else if (delay_pend_in) begin
               phase_in = dicl_pkg::PH_DELAY;
            end else begin
               cmds_left_in  = cmds_dec;
               delay_pend_in = 1'b0;
               phase_in      = finish_phase;
            end
         end
         dicl_pkg::PH_ARG: begin
            res_valid     = 1'b1;
            args_left_in  = args_dec;
            res.kind      = dicl_pkg::KIND_ARG;
            res.value     = {8'd0, in_byte};
            res.frame_end = (args_dec == '0);
            res.list_done = res.frame_end && !delay_pend_ff && last_cmd;
            if (args_dec == '0) begin
               if (delay_pend_ff) begin
                  phase_in = dicl_pkg::PH_DELAY;
               end else begin
                  cmds_left_in  = cmds_dec;
                  delay_pend_in = 1'b0;
                  phase_in      = finish_phase;
               end
            end
         end
         dicl_pkg::PH_DELAY: begin
            res_valid     = 1'b1;
            res.kind      = dicl_pkg::KIND_DELAY;
            res.value     = (in_byte == dicl_pkg::LONG_MARKER) ? long_delay
                                                               : {8'd0, in_byte};
            res.list_done = last_cmd;
            cmds_left_in  = cmds_dec;
            delay_pend_in = 1'b0;
            phase_in      = finish_phase;
         end
         default: begin
            if (in_byte == '0) begin
               res_valid     = 1'b1;
               res.list_done = 1'b1;
               cmds_left_in  = '0;
               phase_in      = dicl_pkg::PH_COUNT;
            end else begin
               cmds_left_in  = in_byte;
               args_left_in  = '0;
               delay_pend_in = 1'b0;
               phase_in      = dicl_pkg::PH_CMD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= dicl_pkg::PH_COUNT;
         cmds_left_ff  <= '0;
         args_left_ff  <= '0;
         delay_pend_ff <= 1'b0;
         held_cmd_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         cmds_left_ff  <= cmds_left_in;
         args_left_ff  <= args_left_in;
         delay_pend_ff <= delay_pend_in;
         held_cmd_ff   <= held_cmd_in;
      end
   end

   `DICL_ASSERT_NEXT(a_cmd_then_nargs, clock, reset,
      step && (phase_ff == dicl_pkg::PH_CMD), phase_ff == dicl_pkg::PH_NARGS)
   `DICL_ASSERT_NEXT(a_done_returns_idle, clock, reset,
      step && res_valid && res.list_done, phase_ff == dicl_pkg::PH_COUNT)
   `DICL_ASSERT_NOW(a_active_has_cmds, clock, reset,
      phase_ff != dicl_pkg::PH_COUNT, cmds_left_ff != '0)
   `DICL_ASSERT_NOW(a_idle_no_args, clock, reset,
      phase_ff == dicl_pkg::PH_COUNT, (args_left_ff == '0) && !delay_pend_ff)

endmodule

@@ hw/rtl/dicl_out_reg.sv @@
// Result register driving the link event channel.
// Depends on dicl_pkg and dicl_rsp_if.
module dicl_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dicl_pkg::result_type  res,
   output logic                  can_load,
   dicl_rsp_if.source            rsp_port
);

   logic                  valid_ff, valid_in;
   dicl_pkg::result_type  res_ff;

   assign can_load = !valid_ff || rsp_port.ready;
   assign valid_in = load || (valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_port.valid            = valid_ff;
   assign rsp_port.out_kind         = res_ff.kind;
   assign rsp_port.out_value        = res_ff.value;
   assign rsp_port.data_not_command = res_ff.data_not_command;
   assign rsp_port.frame_end        = res_ff.frame_end;
   assign rsp_port.list_done        = res_ff.list_done;

endmodule

@@ bench/display_init_command_list_player_top_tb.sv @@
// Self-checking bench for display_init_command_list_player_top: drives list bytes,
// predicts link events in a local model or takes them from directed rows, and checks each result word.
// Depends on dicl_pkg, dicl_req_if, dicl_rsp_if, dicl_csr_if and the RTL top level.
`timescale 1ns / 100ps

module display_init_command_list_player_top_tb;
   import dicl_pkg::*;

   localparam int unsigned RANDOM_PER_PHASE = 300;
   localparam int unsigned LONG_HOLD        = 300;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES    = 8;

   typedef enum logic [1:0] {
      ROW_PREDICT = 2'd0,
      ROW_RESULT  = 2'd1,
      ROW_QUIET   = 2'd2
   } row_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] list_byte;
      row_mode_type      mode;
      result_type        result;
   } row_type;

   localparam result_type NO_EVENT = '0;

   localparam int unsigned DIRECTED_COUNT = 23;
   localparam row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{8'h00, ROW_RESULT,  '{KIND_EMPTY, 16'd0,      1'b1, 1'b0, 1'b1}},
      '{8'h03, ROW_QUIET,   NO_EVENT},
      '{8'hFF, ROW_QUIET,   NO_EVENT},
      '{8'h80, ROW_RESULT,  '{KIND_CMD,   16'h00FF,   1'b0, 1'b1, 1'b0}},
      '{8'hFF, ROW_RESULT,  '{KIND_DELAY, LONG_RESET, 1'b1, 1'b0, 1'b0}},
      '{8'h00, ROW_QUIET,   NO_EVENT},
      '{8'h02, ROW_RESULT,  '{KIND_CMD,   16'h0000,   1'b0, 1'b0, 1'b0}},
      '{8'h00, ROW_RESULT,  '{KIND_ARG,   16'h0000,   1'b1, 1'b0, 1'b0}},
      '{8'hFF, ROW_RESULT,  '{KIND_ARG,   16'h00FF,   1'b1, 1'b1, 1'b0}},
      '{8'h2A, ROW_QUIET,   NO_EVENT},
      '{8'h81, ROW_RESULT,  '{KIND_CMD,   16'h002A,   1'b0, 1'b0, 1'b0}},
      '{8'h55, ROW_RESULT,  '{KIND_ARG,   16'h0055,   1'b1, 1'b1, 1'b0}},
      '{8'h00, ROW_RESULT,  '{KIND_DELAY, 16'h0000,   1'b1, 1'b0, 1'b1}},
      '{8'h01, ROW_QUIET,   NO_EVENT},
      '{8'h11, ROW_QUIET,   NO_EVENT},
      '{8'h00, ROW_RESULT,  '{KIND_CMD,   16'h0011,   1'b0, 1'b1, 1'b1}},
      '{8'h02, ROW_PREDICT, NO_EVENT},
      '{8'hA5, ROW_PREDICT, NO_EVENT},
      '{8'h01, ROW_PREDICT, NO_EVENT},
      '{8'h7E, ROW_PREDICT, NO_EVENT},
      '{8'h5A, ROW_PREDICT, NO_EVENT},
      '{8'h80, ROW_PREDICT, NO_EVENT},
      '{8'hFE, ROW_PREDICT, NO_EVENT}
   };

   logic clock = 1'b0;
   logic reset;

   dicl_req_if req_if ();
   dicl_rsp_if rsp_if ();
   dicl_csr_if csr_if ();

   display_init_command_list_player_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // local copy of the list player state
   phase_type          model_phase = PH_COUNT;
   logic [7:0]         model_cmds_left;
   logic [ARGS_W-1:0]  model_args_left;
   logic               model_delay_pending;
   logic [7:0]         model_held_cmd;
   logic [VALUE_W-1:0] model_long_delay;

   result_type  expected_events [$];
   row_type     offered_rows [$];

   int unsigned error_count      = 0;
   int unsigned events_checked   = 0;
   int unsigned delays_checked   = 0;
   int unsigned sent_items       = 0;
   int unsigned settings_written = 0;
   int unsigned idle_cycles      = 0;
   int unsigned send_idle_pct    = 0;
   int unsigned recv_idle_pct    = 0;
   int unsigned hold_requests    = 0;
   int unsigned holds_served     = 0;

   function automatic void close_command();
      model_cmds_left     = model_cmds_left - 8'd1;
      model_delay_pending = 1'b0;
      if (model_cmds_left == 8'd0) begin
         model_phase = PH_COUNT;
      end else begin
         model_phase = PH_CMD;
      end
   endfunction

   function automatic void decode_list_byte(input logic [7:0] b, output bit emits,
                                            output result_type ev);
      logic fend;
      emits = 1'b1;
      ev    = NO_EVENT;
      case (model_phase)
         PH_CMD: begin
            model_held_cmd = b;
            model_phase    = PH_NARGS;
            emits          = 1'b0;
         end
         PH_NARGS: begin
            model_args_left     = b[6:0];
            model_delay_pending = b[7];
            fend = (model_args_left == '0);
            ev = '{KIND_CMD, {8'h00, model_held_cmd}, 1'b0, fend,
                   fend && !model_delay_pending && (model_cmds_left == 8'd1)};
            if (model_args_left != '0) begin
               model_phase = PH_ARG;
            end else if (model_delay_pending) begin
               model_phase = PH_DELAY;
            end else begin
               close_command();
            end
         end
         PH_ARG: begin
            model_args_left = model_args_left - 1'b1;
            fend = (model_args_left == '0);
            ev = '{KIND_ARG, {8'h00, b}, 1'b1, fend,
                   fend && !model_delay_pending && (model_cmds_left == 8'd1)};
            if (fend) begin
               if (model_delay_pending) begin
                  model_phase = PH_DELAY;
               end else begin
                  close_command();
               end
            end
         end
         PH_DELAY: begin
            ev = '{KIND_DELAY, (b == LONG_MARKER) ? model_long_delay : {8'h00, b},
                   1'b1, 1'b0, (model_cmds_left == 8'd1)};
            close_command();
         end
         default: begin
            if (b == 8'd0) begin
               model_cmds_left = 8'd0;
               model_phase     = PH_COUNT;
               ev = '{KIND_EMPTY, 16'd0, 1'b1, 1'b0, 1'b1};
            end else begin
               model_cmds_left     = b;
               model_args_left     = '0;
               model_delay_pending = 1'b0;
               model_phase         = PH_CMD;
               emits               = 1'b0;
            end
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // checker, predictor and watchdog, all sampled at the rising edge
   always @(posedge clock) begin
      result_type ev;
      row_type    row;
      bit         emits;
      if (reset) begin
         model_phase         = PH_COUNT;
         model_cmds_left     = 8'd0;
         model_args_left     = '0;
         model_delay_pending = 1'b0;
         model_held_cmd      = 8'd0;
         model_long_delay    = LONG_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected link event: kind %0d value %0d",
                      rsp_if.out_kind, rsp_if.out_value);
               error_count++;
            end else begin
               ev = expected_events.pop_front();
               compare_field("out_kind", ev.kind, rsp_if.out_kind);
               compare_field("out_value", ev.value, rsp_if.out_value);
               compare_field("data_not_command", ev.data_not_command,
                             rsp_if.data_not_command);
               compare_field("frame_end", ev.frame_end, rsp_if.frame_end);
               compare_field("list_done", ev.list_done, rsp_if.list_done);
               events_checked++;
               if (ev.kind == KIND_DELAY) delays_checked++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            row = offered_rows.pop_front();
            decode_list_byte(req_if.list_byte, emits, ev);
            case (row.mode)
               ROW_RESULT: expected_events.push_back(row.result);
               ROW_QUIET:  ;
               default: begin
                  if (emits) expected_events.push_back(ev);
               end
            endcase
         end
         if (csr_if.valid && csr_if.ready) begin
            model_long_delay = csr_if.long_delay_ms;
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result sink: random back-pressure plus one long hold-off
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input row_mode_type mode,
                            input result_type typed);
      row_type row;
      row = '{b, mode, typed};
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.list_byte <= b;
      offered_rows.push_back(row);
      sent_items++;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random_list(input bit big);
      int unsigned roll;
      int unsigned n_cmds;
      int unsigned n_args;
      bit          with_delay;
      roll = $urandom_range(99);
      if (big) n_cmds = 255;
      else if (roll < 6) n_cmds = 0;
      else if (roll < 9) n_cmds = $urandom_range(7, 40);
      else n_cmds = $urandom_range(1, 5);
      send_byte(8'(n_cmds), ROW_PREDICT, NO_EVENT);
      for (int c = 0; c < n_cmds; c++) begin
         roll = $urandom_range(99);
         if (big || n_cmds > 6) n_args = $urandom_range(0, 1);
         else if (roll < 1) n_args = 127;
         else n_args = $urandom_range(0, 5);
         with_delay = $urandom_range(1);
         send_byte(8'($urandom_range(255)), ROW_PREDICT, NO_EVENT);
         send_byte({with_delay, 7'(n_args)}, ROW_PREDICT, NO_EVENT);
         repeat (n_args) send_byte(8'($urandom_range(255)), ROW_PREDICT, NO_EVENT);
         if (with_delay) begin
            send_byte(($urandom_range(99) < 30) ? LONG_MARKER : 8'($urandom_range(254)),
                      ROW_PREDICT, NO_EVENT);
         end
      end
   endtask

   // stop offering, let every pending event come out, then let the pipe settle
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_long_delay(input logic [VALUE_W-1:0] value);
      csr_if.valid         <= 1'b1;
      csr_if.long_delay_ms <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      settings_written++;
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.list_byte     <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.long_delay_ms <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 57;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_byte(DIRECTED_ROWS[i].list_byte, DIRECTED_ROWS[i].mode,
                   DIRECTED_ROWS[i].result);
      end

      for (int p = 0; p < 5; p++) begin
         drain_pipeline();
         case (p)
            0: write_long_delay(16'h0000);
            1: write_long_delay(16'hFFFF);
            3: write_long_delay(16'd1);
            default: write_long_delay(16'($urandom_range(65535)));
         endcase
         if (p < 2) begin
            send_idle_pct = 10;
            recv_idle_pct = 57;
         end else if (p < 4) begin
            send_idle_pct = 57;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 2) hold_requests++;
         if (p == 4) send_random_list(1'b1);
         while (sent_items < DIRECTED_COUNT + (p + 1) * RANDOM_PER_PHASE) begin
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(1, 3))
                  send_byte(8'($urandom_range(255)), ROW_PREDICT, NO_EVENT);
            end else begin
               send_random_list(1'b0);
            end
         end
      end
      drain_pipeline();

      $display("Covered %0d list bytes and %0d link events (%0d delay requests)",
               sent_items, events_checked, delays_checked);
      $display("across %0d long delay settings and three back-pressure mixes",
               settings_written + 1);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dicl_pkg.sv
hw/rtl/dicl_req_if.sv
hw/rtl/dicl_rsp_if.sv
hw/rtl/dicl_csr_if.sv
hw/rtl/dicl_list_fsm.sv
hw/rtl/dicl_out_reg.sv
hw/rtl/display_init_command_list_player_top.sv
bench/display_init_command_list_player_top_tb.sv
